/* design/srtt_pkg.sv */
// Shared types, codes and helpers for the session retry timer table.
// Used by srtt_cell, srtt_head and session_retry_timer_table_core.
package srtt_pkg;

    localparam int ID_W       = 8;
    localparam int TMR_W      = 16;
    localparam int RTY_W      = 8;
    localparam int REQ_W      = 3;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    // Request codes carried in the input beat's tuser.
    localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ARM   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TICK  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY = 3'd4;

    // Event codes carried in the output beat's tuser.
    localparam logic [KIND_W-1:0] EV_ALLOC = 3'd0;
    localparam logic [KIND_W-1:0] EV_ARM   = 3'd1;
    localparam logic [KIND_W-1:0] EV_CLEAR = 3'd2;
    localparam logic [KIND_W-1:0] EV_QUERY = 3'd3;
    localparam logic [KIND_W-1:0] EV_RETX  = 3'd4;
    localparam logic [KIND_W-1:0] EV_FAIL  = 3'd5;
    localparam logic [KIND_W-1:0] EV_DONE  = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 1'd1;

    localparam logic [TMR_W-1:0] TIMEOUT_RST = 16'd3000;
    localparam logic [RTY_W-1:0] LIMIT_RST   = 8'd3;
    localparam logic [ID_W-1:0]  IDENT_RST   = 8'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_REPORT
    } t_state;

    // Kind of pass the ring is making.
    typedef enum logic [1:0] {
        PASS_TICK,
        PASS_FIND,
        PASS_CHECK,
        PASS_WRITE
    } t_pass;

    typedef struct packed {
        logic [ID_W-1:0]  ident;
        logic             waiting;
        logic [TMR_W-1:0] timer;
        logic [RTY_W-1:0] retries;
    } t_slot;

    typedef struct packed {
        t_pass            pass;
        logic [REQ_W-1:0] req;
        logic [ID_W-1:0]  tid;
        logic [TMR_W-1:0] elapsed;
        logic [TMR_W-1:0] timeout;
        logic [RTY_W-1:0] limit;
        logic [ID_W-1:0]  cand;
        logic             at_free;
        logic             found_before;
    } t_head_ctl;

    typedef struct packed {
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [RTY_W-1:0]  att;
        logic              hit;
        logic              held;
        logic              free;
    } t_head_evt;

    // Next session id: 1 to 255, skipping 0 on wrap.
    function automatic logic [ID_W-1:0] f_bump_ident(input logic [ID_W-1:0] v);
        logic [ID_W-1:0] s;
        s = v + 1'b1;
        return (s == '0) ? IDENT_RST : s;
    endfunction

endpackage

/* design/srtt_cell.sv */
// One slot of the session ring: id, waiting bit, timer and retry count.
// Depends on srtt_pkg for the slot type.
module srtt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  srtt_pkg::t_slot i_slot,
    output srtt_pkg::t_slot o_slot
);

    srtt_pkg::t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_shift) begin
            r_slot <= i_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

/* design/srtt_head.sv */
// Update logic for the slot passing the head of the ring.
// Applies tick, find, id check or allocation write; depends on srtt_pkg.
module srtt_head (
    input  srtt_pkg::t_slot     i_slot,
    input  srtt_pkg::t_head_ctl i_ctl,
    output srtt_pkg::t_slot     o_slot,
    output srtt_pkg::t_head_evt o_evt
);

    logic [srtt_pkg::TMR_W-1:0] w_left;

    assign w_left = (i_slot.timer > i_ctl.elapsed) ? (i_slot.timer - i_ctl.elapsed) : '0;

    always_comb begin
        o_slot = i_slot;
        o_evt  = '0;
        case (i_ctl.pass)
            srtt_pkg::PASS_TICK: begin
                if (i_slot.waiting) begin
                    if (w_left != '0) begin
                        o_slot.timer = w_left;
                    end else if (i_slot.retries < i_ctl.limit) begin
                        o_slot.timer   = i_ctl.timeout;
                        o_slot.retries = i_slot.retries + 1'b1;
                        o_evt.emit     = 1'b1;
                        o_evt.kind     = srtt_pkg::EV_RETX;
                        o_evt.id       = i_slot.ident;
                        o_evt.att      = o_slot.retries;
                    end else begin
                        o_slot.waiting = 1'b0;
                        o_slot.ident   = '0;
                        o_evt.emit     = 1'b1;
                        o_evt.kind     = srtt_pkg::EV_FAIL;
                        o_evt.id       = i_slot.ident;
                        o_evt.att      = i_slot.retries;
                    end
                end
            end
            srtt_pkg::PASS_FIND: begin
                if (i_ctl.tid != '0 && i_slot.ident == i_ctl.tid && !i_ctl.found_before) begin
                    o_evt.hit = 1'b1;
                    case (i_ctl.req)
                        srtt_pkg::REQ_ARM: begin
                            o_slot.waiting = 1'b1;
                            o_slot.retries = '0;
                            o_slot.timer   = i_ctl.timeout;
                        end
                        srtt_pkg::REQ_CLEAR: begin
                            o_slot.waiting = 1'b0;
                            o_slot.ident   = '0;
                        end
                        default: begin
                        end
                    endcase
                    o_evt.att = o_slot.retries;
                end
            end
            srtt_pkg::PASS_CHECK: begin
                o_evt.held = (i_slot.ident == i_ctl.cand);
                o_evt.free = (i_slot.ident == '0);
            end
            srtt_pkg::PASS_WRITE: begin
                if (i_ctl.at_free) begin
                    o_slot.ident   = i_ctl.cand;
                    o_slot.waiting = 1'b0;
                    o_slot.timer   = i_ctl.timeout;
                    o_evt.hit      = 1'b1;
                    o_evt.att      = i_slot.retries;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* design/session_retry_timer_table_core.sv */
// Session retry timer table: top level with the slot ring and its sequencer.
// Depends on srtt_pkg, srtt_cell and srtt_head.

// The SESSIONS slots sit in a ring of cells that rotates one slot per cycle past
// a single update unit, as long as the output is not stalled, so every request is
// handled by whole passes of the ring. Tick, arm, clear and query take one pass.
// Allocate takes one check pass per id candidate it tries (at most SESSIONS
// candidates), then one write pass; a full table answers after the first pass.
// Input beats are taken only between requests, while an earlier result may
// still wait at the output. Tick events leave in slot order, one beat each,
// followed by a tick done beat with tlast set; every other defined request gives
// a single beat with tlast set, and a request of an undefined code gives none.
module session_retry_timer_table_core #(
    parameter int SESSIONS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [srtt_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [srtt_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] target_id, [23:8] elapsed_ms
    input  logic [srtt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [2:0] req_type
    input  logic [srtt_pkg::REQ_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] result_id, [8] ok_flag, [16:9] attempt_count, [23:17] zero
    output logic [srtt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [2:0] event_kind
    output logic [srtt_pkg::KIND_W-1:0]        m_axis_tuser,
    output logic                               m_axis_tlast
);

    localparam int POS_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(SESSIONS - 1);

    srtt_pkg::t_state n_state, r_state;
    srtt_pkg::t_pass  r_pass;

    logic [POS_W-1:0]                r_pos;
    logic [POS_W-1:0]                r_free_pos;
    logic                            r_free_found;
    logic                            r_held;
    logic                            r_found;
    logic [srtt_pkg::RTY_W-1:0]      r_att;
    logic [srtt_pkg::REQ_W-1:0]      r_req;
    logic [srtt_pkg::ID_W-1:0]       r_tid;
    logic [srtt_pkg::TMR_W-1:0]      r_elapsed;
    logic [srtt_pkg::ID_W-1:0]       r_cand;
    logic [srtt_pkg::ID_W-1:0]       r_next_ident;
    logic [srtt_pkg::TMR_W-1:0]      r_timeout;
    logic [srtt_pkg::RTY_W-1:0]      r_limit;

    logic                            r_out_valid;
    logic [srtt_pkg::KIND_W-1:0]     r_out_kind;
    logic [srtt_pkg::ID_W-1:0]       r_out_id;
    logic                            r_out_ok;
    logic [srtt_pkg::RTY_W-1:0]      r_out_att;
    logic                            r_out_last;

    logic                            w_accept;
    logic                            w_req_ok;
    logic                            w_out_free;
    logic                            w_step;
    logic                            w_load;
    logic [srtt_pkg::KIND_W-1:0]     w_kind;
    logic [srtt_pkg::ID_W-1:0]       w_id;
    logic                            w_ok;
    logic [srtt_pkg::RTY_W-1:0]      w_att;
    logic                            w_last;

    logic [srtt_pkg::REQ_W-1:0]      w_in_req;
    logic [srtt_pkg::ID_W-1:0]       w_in_tid;
    logic [srtt_pkg::TMR_W-1:0]      w_in_elapsed;

    srtt_pkg::t_slot     w_cell [SESSIONS];
    srtt_pkg::t_slot     w_head_out;
    srtt_pkg::t_head_ctl w_ctl;
    srtt_pkg::t_head_evt w_evt;

    assign w_in_req     = s_axis_tuser;
    assign w_in_tid     = s_axis_tdata[7:0];
    assign w_in_elapsed = s_axis_tdata[23:8];

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_req_ok   = (w_in_req == srtt_pkg::REQ_ALLOC) || (w_in_req == srtt_pkg::REQ_ARM)
                     || (w_in_req == srtt_pkg::REQ_CLEAR) || (w_in_req == srtt_pkg::REQ_TICK)
                     || (w_in_req == srtt_pkg::REQ_QUERY);
    assign w_out_free = !r_out_valid || m_axis_tready;

    // Ring of slots: each cell takes its upper neighbor, the top cell takes
    // the updated head slot, so a full pass restores the original order.
    for (genvar k = 0; k < SESSIONS; k++) begin : g_ring
        if (k == SESSIONS - 1) begin : g_tail
            srtt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_step),
                .i_slot  (w_head_out),
                .o_slot  (w_cell[k])
            );
        end else begin : g_body
            srtt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_step),
                .i_slot  (w_cell[k+1]),
                .o_slot  (w_cell[k])
            );
        end
    end

    always_comb begin
        w_ctl              = '0;
        w_ctl.pass         = r_pass;
        w_ctl.req          = r_req;
        w_ctl.tid          = r_tid;
        w_ctl.elapsed      = r_elapsed;
        w_ctl.timeout      = r_timeout;
        w_ctl.limit        = r_limit;
        w_ctl.cand         = r_cand;
        w_ctl.at_free      = (r_pos == r_free_pos);
        w_ctl.found_before = r_found;
    end

    srtt_head u_head (
        .i_slot (w_cell[0]),
        .i_ctl  (w_ctl),
        .o_slot (w_head_out),
        .o_evt  (w_evt)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            srtt_pkg::ST_IDLE: begin
                if (w_accept && w_req_ok) begin
                    n_state = srtt_pkg::ST_SCAN;
                end
            end
            srtt_pkg::ST_SCAN: begin
                if (w_step && r_pos == LAST_POS) begin
                    n_state = srtt_pkg::ST_DECIDE;
                end
            end
            srtt_pkg::ST_DECIDE: begin
                if (r_pass == srtt_pkg::PASS_CHECK && r_free_found) begin
                    n_state = srtt_pkg::ST_SCAN;
                end else begin
                    n_state = srtt_pkg::ST_REPORT;
                end
            end
            srtt_pkg::ST_REPORT: begin
                if (w_out_free) begin
                    n_state = srtt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srtt_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: ring step and result beat.
    always_comb begin
        s_axis_tready = 1'b0;
        w_step        = 1'b0;
        w_load        = 1'b0;
        w_kind        = srtt_pkg::EV_DONE;
        w_id          = '0;
        w_ok          = 1'b1;
        w_att         = '0;
        w_last        = 1'b1;
        case (r_state)
            srtt_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            srtt_pkg::ST_SCAN: begin
                w_step = w_out_free;
                if (w_out_free && w_evt.emit) begin
                    w_load = 1'b1;
                    w_kind = w_evt.kind;
                    w_id   = w_evt.id;
                    w_att  = w_evt.att;
                    w_last = 1'b0;
                end
            end
            srtt_pkg::ST_REPORT: begin
                w_load = w_out_free;
                case (r_pass)
                    srtt_pkg::PASS_TICK: begin
                        w_kind = srtt_pkg::EV_DONE;
                    end
                    srtt_pkg::PASS_FIND: begin
                        if (r_req == srtt_pkg::REQ_ARM) begin
                            w_kind = srtt_pkg::EV_ARM;
                        end else if (r_req == srtt_pkg::REQ_CLEAR) begin
                            w_kind = srtt_pkg::EV_CLEAR;
                        end else begin
                            w_kind = srtt_pkg::EV_QUERY;
                        end
                        w_id  = r_tid;
                        w_ok  = r_found;
                        w_att = r_found ? r_att : '0;
                    end
                    srtt_pkg::PASS_CHECK: begin
                        // Only reached when the table was full.
                        w_kind = srtt_pkg::EV_ALLOC;
                        w_ok   = 1'b0;
                    end
                    srtt_pkg::PASS_WRITE: begin
                        w_kind = srtt_pkg::EV_ALLOC;
                        w_id   = r_cand;
                        w_att  = r_att;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= srtt_pkg::ST_IDLE;
            r_pass       <= srtt_pkg::PASS_TICK;
            r_pos        <= '0;
            r_free_found <= 1'b0;
            r_held       <= 1'b0;
            r_found      <= 1'b0;
            r_next_ident <= srtt_pkg::IDENT_RST;
            r_timeout    <= srtt_pkg::TIMEOUT_RST;
            r_limit      <= srtt_pkg::LIMIT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    srtt_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_wdata;
                    srtt_pkg::CFG_LIMIT:   r_limit   <= i_cfg_wdata[srtt_pkg::RTY_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (r_state == srtt_pkg::ST_IDLE && w_accept) begin
                r_pos        <= '0;
                r_free_found <= 1'b0;
                r_held       <= 1'b0;
                r_found      <= 1'b0;
                r_cand       <= (r_next_ident == '0) ? srtt_pkg::IDENT_RST : r_next_ident;
                if (w_in_req == srtt_pkg::REQ_ALLOC) begin
                    r_pass <= srtt_pkg::PASS_CHECK;
                end else if (w_in_req == srtt_pkg::REQ_TICK) begin
                    r_pass <= srtt_pkg::PASS_TICK;
                end else begin
                    r_pass <= srtt_pkg::PASS_FIND;
                end
            end

            if (w_step) begin
                r_pos <= (r_pos == LAST_POS) ? '0 : r_pos + 1'b1;
                if (w_evt.hit) begin
                    r_found <= 1'b1;
                    r_att   <= w_evt.att;
                end
                if (w_evt.held) begin
                    r_held <= 1'b1;
                end
                if (w_evt.free && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_pos   <= r_pos;
                end
            end

            if (r_state == srtt_pkg::ST_DECIDE) begin
                if (r_pass == srtt_pkg::PASS_CHECK && r_free_found) begin
                    if (r_held) begin
                        // Candidate already in use: try the next id.
                        r_cand       <= srtt_pkg::f_bump_ident(r_cand);
                        r_held       <= 1'b0;
                        r_free_found <= 1'b0;
                    end else begin
                        r_pass <= srtt_pkg::PASS_WRITE;
                    end
                end else if (r_pass == srtt_pkg::PASS_WRITE) begin
                    r_next_ident <= srtt_pkg::f_bump_ident(r_cand);
                end
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == srtt_pkg::ST_IDLE && w_accept) begin
            r_req     <= w_in_req;
            r_tid     <= w_in_tid;
            r_elapsed <= w_in_elapsed;
        end
        if (w_load) begin
            r_out_kind <= w_kind;
            r_out_id   <= w_id;
            r_out_ok   <= w_ok;
            r_out_att  <= w_att;
            r_out_last <= w_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {7'b0, r_out_att, r_out_ok, r_out_id};

endmodule

/* sim/tb_session_retry_timer_table_core.sv */
// Self-checking bench for session_retry_timer_table_core: request beats go in on the
// slave stream, result beats are compared with a behavioral copy of the session table.
// Depends on srtt_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_session_retry_timer_table_core;
    import srtt_pkg::*;

    localparam int SESSIONS      = 8;
    localparam int SETTLE_CYCLES = (SESSIONS + 2) * (SESSIONS + 1) + 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_CYCLES  = 2000000;

    // Request codes past the last defined one are ignored by the block.
    localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = REQ_QUERY + 1'b1;
    localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = {REQ_W{1'b1}};

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [ID_W-1:0]  tid;
        logic [TMR_W-1:0] el;
    } t_session_req;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic              ok;
        logic [RTY_W-1:0]  att;
        logic              last;
    } t_session_event;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [REQ_W-1:0]       s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [KIND_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    session_retry_timer_table_core #(
        .SESSIONS(SESSIONS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the session table and its registers.
    logic [ID_W-1:0]  tbl_ident   [SESSIONS];
    logic             tbl_waiting [SESSIONS];
    logic [TMR_W-1:0] tbl_timer   [SESSIONS];
    logic [RTY_W-1:0] tbl_retries [SESSIONS];
    logic [ID_W-1:0]  next_ident;
    logic [TMR_W-1:0] cfg_timeout;
    logic [RTY_W-1:0] cfg_limit;

    t_session_req   req_fifo[$];
    t_session_event due_events[$];
    t_session_req   on_wire;
    t_session_event want;

    int  beats_issued   = 0;
    int  beats_taken    = 0;
    int  events_checked = 0;
    int  fail_count     = 0;
    int  n_retx         = 0;
    int  n_fail         = 0;
    int  n_full         = 0;
    int  n_ignored      = 0;
    int  gap_left       = 0;
    int  stall_left     = 0;
    int  hold_left      = 0;
    int  cycle_cnt      = 0;
    bit  hold_ask       = 1'b0;
    bit  hold_taken     = 1'b0;
    bit  no_idle        = 1'b0;

    function automatic int find_ident(input logic [ID_W-1:0] id);
        for (int k = 0; k < SESSIONS; k++) begin
            if (tbl_ident[k] == id) return k;
        end
        return SESSIONS;
    endfunction

    function automatic logic [ID_W-1:0] ident_after(input logic [ID_W-1:0] v);
        logic [ID_W-1:0] w;
        w = v + 1'b1;
        return (w == '0) ? IDENT_RST : w;
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_event(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                             input logic ok, input logic [RTY_W-1:0] att);
        t_session_event ev;
        ev.kind = kind;
        ev.id   = id;
        ev.ok   = ok;
        ev.att  = att;
        ev.last = 1'b0;
        due_events.push_back(ev);
    endtask

    // Applies one accepted request to the shadow table and queues its results.
    task automatic apply_to_table(input t_session_req r);
        int                s;
        int                n0;
        logic [KIND_W-1:0] kind;
        t_session_event    ev;
        n0 = due_events.size();
        case (r.req)
            REQ_ALLOC: begin
                s = find_ident('0);
                if (s >= SESSIONS) begin
                    add_event(EV_ALLOC, '0, 1'b0, '0);
                    n_full++;
                end else begin
                    while (find_ident(next_ident) < SESSIONS)
                        next_ident = ident_after(next_ident);
                    tbl_ident[s]   = next_ident;
                    tbl_waiting[s] = 1'b0;
                    tbl_timer[s]   = cfg_timeout;
                    add_event(EV_ALLOC, next_ident, 1'b1, tbl_retries[s]);
                    next_ident = ident_after(next_ident);
                end
            end
            REQ_ARM, REQ_CLEAR, REQ_QUERY: begin
                kind = (r.req == REQ_ARM) ? EV_ARM : (r.req == REQ_CLEAR) ? EV_CLEAR : EV_QUERY;
                s = (r.tid == '0) ? SESSIONS : find_ident(r.tid);
                if (s >= SESSIONS) begin
                    add_event(kind, r.tid, 1'b0, '0);
                end else begin
                    if (r.req == REQ_ARM) begin
                        tbl_waiting[s] = 1'b1;
                        tbl_retries[s] = '0;
                        tbl_timer[s]   = cfg_timeout;
                    end else if (r.req == REQ_CLEAR) begin
                        tbl_waiting[s] = 1'b0;
                        tbl_ident[s]   = '0;
                    end
                    add_event(kind, r.tid, 1'b1, tbl_retries[s]);
                end
            end
            REQ_TICK: begin
                for (int k = 0; k < SESSIONS; k++) begin
                    if (tbl_waiting[k]) begin
                        tbl_timer[k] = (tbl_timer[k] > r.el) ? tbl_timer[k] - r.el : '0;
                        if (tbl_timer[k] == '0) begin
                            if (tbl_retries[k] < cfg_limit) begin
                                tbl_timer[k]   = cfg_timeout;
                                tbl_retries[k] = tbl_retries[k] + 1'b1;
                                add_event(EV_RETX, tbl_ident[k], 1'b1, tbl_retries[k]);
                                n_retx++;
                            end else begin
                                add_event(EV_FAIL, tbl_ident[k], 1'b1, tbl_retries[k]);
                                tbl_waiting[k] = 1'b0;
                                tbl_ident[k]   = '0;
                                n_fail++;
                            end
                        end
                    end
                end
                add_event(EV_DONE, '0, 1'b1, '0);
            end
            default: n_ignored++;
        endcase
        if (due_events.size() > n0) begin
            ev = due_events.pop_back();
            ev.last = 1'b1;
            due_events.push_back(ev);
        end
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_to_table(on_wire);
                beats_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0 && !no_idle) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_fifo.size() > 0) begin
                    on_wire = req_fifo.pop_front();
                    s_axis_tuser  <= on_wire.req;
                    s_axis_tdata  <= {on_wire.el, on_wire.tid};
                    s_axis_tvalid <= 1'b1;
                    gap_left = no_idle ? 0 : pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Result monitor and receiver back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_events.size() == 0) begin
                    $error("result beat with nothing outstanding: kind %0d, id %0d",
                           m_axis_tuser, m_axis_tdata[7:0]);
                    fail_count++;
                end else begin
                    want = due_events.pop_front();
                    check_field("event_kind", 32'(want.kind), 32'(m_axis_tuser));
                    check_field("result_id", 32'(want.id), 32'(m_axis_tdata[7:0]));
                    check_field("ok_flag", 32'(want.ok), 32'(m_axis_tdata[8]));
                    check_field("attempt_count", 32'(want.att), 32'(m_axis_tdata[16:9]));
                    check_field("tdata padding", 32'd0, 32'(m_axis_tdata[23:17]));
                    check_field("last_flag", 32'(want.last), 32'(m_axis_tlast));
                    events_checked++;
                end
            end
            if (hold_ask && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (no_idle) begin
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                m_axis_tready <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, due_events.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] tid,
                        input logic [TMR_W-1:0] el);
        t_session_req r;
        r.req = req;
        r.tid = tid;
        r.el  = el;
        req_fifo.push_back(r);
        beats_issued++;
    endtask

    // Random id and elapsed fields for beats that do not use them.
    function automatic logic [ID_W-1:0] any_id();
        return ID_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [TMR_W-1:0] any_ms();
        return TMR_W'($urandom_range(0, 65535));
    endfunction

    // Waits until every request is in and every result is out, then lets any
    // result-free request drain from the block.
    task automatic settle();
        while (beats_taken != beats_issued || due_events.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [TMR_W-1:0] timeout, input logic [RTY_W-1:0] limit);
        logic [CFG_DATA_W-RTY_W-1:0] junk;
        junk = (CFG_DATA_W-RTY_W)'($urandom_range(0, 255));
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_TIMEOUT;
        i_cfg_wdata <= timeout;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_LIMIT;
        i_cfg_wdata <= {junk, limit};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_timeout = timeout;
        cfg_limit   = limit;
    endtask

    // Mostly ids that the table holds right now, some zero, unknown or fresh.
    function automatic logic [ID_W-1:0] pick_target();
        logic [ID_W-1:0] held[$];
        int              r;
        foreach (tbl_ident[k]) begin
            if (tbl_ident[k] != '0) held.push_back(tbl_ident[k]);
        end
        r = $urandom_range(0, 99);
        if (r < 65 && held.size() > 0) return held[$urandom_range(0, held.size() - 1)];
        if (r < 75) return '0;
        if (r < 85) return next_ident;
        return any_id();
    endfunction

    // Tick lengths are spread around the current timeout so timers expire often.
    function automatic logic [TMR_W-1:0] pick_elapsed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 25) return {TMR_W{1'b1}};
        if (r < 55) return TMR_W'($urandom_range(0, cfg_timeout));
        if (r < 75) return cfg_timeout;
        return any_ms();
    endfunction

    // Churn mode allocates and frees sessions at a high rate.
    task automatic run_random(input int count, input bit churn);
        int               done_cnt;
        int               r;
        logic [REQ_W-1:0] req;
        done_cnt = 0;
        while (done_cnt < count) begin
            while (req_fifo.size() >= 2) @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (churn)
                req = (r < 45) ? REQ_ALLOC : (r < 90) ? REQ_CLEAR :
                      (r < 95) ? REQ_TICK : REQ_QUERY;
            else
                req = (r < 24) ? REQ_ALLOC : (r < 42) ? REQ_ARM : (r < 54) ? REQ_CLEAR :
                      (r < 64) ? REQ_QUERY : (r < 94) ? REQ_TICK :
                      REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
            if (req == REQ_TICK)
                send(req, any_id(), pick_elapsed());
            else
                send(req, pick_target(), any_ms());
            if (req <= REQ_QUERY) done_cnt++;
        end
    endtask

    initial begin
        foreach (tbl_ident[k]) begin
            tbl_ident[k]   = '0;
            tbl_waiting[k] = 1'b0;
            tbl_timer[k]   = '0;
            tbl_retries[k] = '0;
        end
        next_ident  = IDENT_RST;
        cfg_timeout = TIMEOUT_RST;
        cfg_limit   = LIMIT_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset register values.
        send(REQ_QUERY, '0, any_ms());
        send(REQ_ARM, '0, any_ms());
        send(REQ_CLEAR, '0, any_ms());
        send(REQ_QUERY, 8'd5, any_ms());
        send(REQ_TICK, any_id(), '0);
        // Nine allocations: the last one finds the table full.
        repeat (SESSIONS + 1) send(REQ_ALLOC, any_id(), any_ms());
        send(REQ_ARM, 8'd3, any_ms());
        send(REQ_ARM, 8'd8, any_ms());
        send(REQ_TICK, any_id(), TIMEOUT_RST - 1'b1);
        send(REQ_TICK, any_id(), 16'd1);
        // Two more retransmits each, then both sessions fail at the retry limit.
        repeat (3) send(REQ_TICK, any_id(), {TMR_W{1'b1}});
        send(REQ_CLEAR, 8'd1, any_ms());
        // The second of these lands in a failed slot and reports its old retries.
        repeat (2) send(REQ_ALLOC, any_id(), any_ms());
        send(REQ_SPARE_LAST, any_id(), any_ms());
        settle();

        write_regs(16'd1, 8'd0);
        run_random(30, 1'b0);
        settle();

        write_regs({TMR_W{1'b1}}, {RTY_W{1'b1}});
        run_random(20, 1'b0);
        settle();

        write_regs('0, 8'd2);
        run_random(20, 1'b0);
        settle();

        // The receiver stops for a long stretch here while requests keep coming.
        write_regs(TMR_W'($urandom_range(1, 300)), RTY_W'($urandom_range(0, 6)));
        hold_ask = 1'b1;
        run_random(40, 1'b0);
        settle();

        no_idle = 1'b1;
        write_regs(TMR_W'($urandom_range(1, 2000)), RTY_W'($urandom_range(0, 4)));
        run_random(30, 1'b0);
        settle();
        no_idle = 1'b0;

        write_regs(16'd40000, 8'd1);
        run_random(100, 1'b1);
        settle();

        $display("Run covered %0d request beats (%0d of ignored type) and %0d result beats.",
                 beats_taken, n_ignored, events_checked);
        $display("Seen %0d retransmits, %0d session failures, %0d allocations on a full table.",
                 n_retx, n_fail, n_full);
        if (fail_count == 0 && due_events.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
